// ===== hw/rtl/tccs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_pkg: shared types and constants of the text console
// Field widths, function and character codes, config register indexes and
// the microcode control word format.
// ----------------------------------------------------------------------------
package tccs_pkg;

    // Word field widths
    localparam int FUNC_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int RROW_W     = 6;
    localparam int RCOL_W     = 7;
    localparam int CUR_ROW_W  = 6;
    localparam int CUR_COL_W  = 7;

    // Config port
    localparam int CFG_DATA_W = 8;
    localparam int CFG_ROWS_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'd1;
    localparam int COLS_RESET = 80;
    localparam int ROWS_RESET = 25;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TOGGLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HOME   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // Datapath operation of one microcode step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_IDLE,
        OP_NORM,
        OP_TOGGLE,
        OP_HOME,
        OP_BACK,
        OP_READ,
        OP_RDDATA,
        OP_PUT,
        OP_NEWLINE,
        OP_FILL,
        OP_EMIT
    } t_op;

    // Jump condition of one microcode step
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_ACCEPT,
        COND_TOP_OK,
        COND_DISPATCH,
        COND_NO_WRAP,
        COND_NO_SCROLL,
        COND_FILL_DONE,
        COND_CLEAR_DONE,
        COND_OUT_FREE
    } t_cond;

    // Microcode addresses
    typedef logic [3:0] t_step;
    localparam t_step S_CLEAR    = 4'd0;
    localparam t_step S_IDLE     = 4'd1;
    localparam t_step S_NORM     = 4'd2;
    localparam t_step S_DISPATCH = 4'd3;
    localparam t_step S_TOGGLE   = 4'd4;
    localparam t_step S_HOME     = 4'd5;
    localparam t_step S_BACK     = 4'd6;
    localparam t_step S_READ     = 4'd7;
    localparam t_step S_RDDATA   = 4'd8;
    localparam t_step S_PUT      = 4'd9;
    localparam t_step S_NEWLINE  = 4'd10;
    localparam t_step S_FILL     = 4'd11;
    localparam t_step S_EMIT     = 4'd12;

    // Control word: jump to target when cond holds, else stay (hold) or step on
    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  hold;
        t_step target;
    } t_ctrl;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic              accept;
        logic              top_ok;
        logic              no_wrap;
        logic              no_scroll;
        logic              fill_done;
        logic              clear_done;
        logic              out_free;
        logic [FUNC_W-1:0] func;
        logic              is_newline;
        logic              is_backspace;
    } t_status;

    // Result word register
    typedef struct packed {
        logic [CUR_ROW_W-1:0] cursor_row;
        logic [CUR_COL_W-1:0] cursor_col;
        logic                 cursor_inverted;
        logic [CHAR_W-1:0]    cell_char;
        logic                 scrolled;
    } t_result;

endpackage

// ===== hw/rtl/tccs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_in_if: command channel of the text console
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface tccs_in_if import tccs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;

    modport source (output valid, func, char_code, read_row, read_col, input ready);
    modport sink   (input valid, func, char_code, read_row, read_col, output ready);
endinterface

// ===== hw/rtl/tccs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_out_if: result channel of the text console
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface tccs_out_if import tccs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_COL_W-1:0] cursor_col;
    logic                 cursor_inverted;
    logic [CHAR_W-1:0]    cell_char;
    logic                 scrolled;

    modport source (output valid, cursor_row, cursor_col, cursor_inverted, cell_char,
                    scrolled, input ready);
    modport sink   (input valid, cursor_row, cursor_col, cursor_inverted, cell_char,
                    scrolled, output ready);
endinterface

// ===== hw/rtl/text_console_cursor_scroll.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll: text console with cursor, flash flag and scroll
//
// Commands enter on i_cmd (valid/ready) and each gives exactly one word on
// o_res (valid/ready). Config sizes are written on i_cfg_wr_en/i_cfg_index/
// i_cfg_wdata; the user must write them only while no command is in flight,
// as the block itself does not enforce this.
// A microcoded sequencer runs each command: a step to take the word, a step
// to normalize the scroll offset and clip the cursor, one dispatch step, the
// command's own steps and a step to load the result register. A scroll
// writes a space into each column in use of the new bottom row, one at a
// time through the single store write port. The first command after
// rows_in_use shrinks reduces the scroll offset by repeated subtract.
// After reset the character store is swept to zero, one cell a cycle, over
// all MAX_ROWS * 2**ceil(log2(MAX_COLUMNS)) cells (8192 at the defaults);
// i_cmd.ready stays low meanwhile, config writes are taken.
// The result register holds a word until the receiver takes it; the next
// command is accepted meanwhile and waits in its final step if the register
// is still full.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll import tccs_pkg::*; #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    tccs_in_if.sink               i_cmd,
    tccs_out_if.source            o_res
);

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int CNW   = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int RNW   = $clog2(MAX_ROWS + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAX_ROWS * (2 ** CW);
    localparam int RCMP  = (RNW > RROW_W) ? RNW : RROW_W;
    localparam int CCMP  = (CNW > RCOL_W) ? CNW : RCOL_W;
    localparam int CCFG  = (CNW > CFG_DATA_W) ? CNW : CFG_DATA_W;
    localparam int RCFG  = (RNW > CFG_ROWS_W) ? RNW : CFG_ROWS_W;
    localparam int COLS_RST = (COLS_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COLS_RESET;
    localparam int ROWS_RST = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;

    t_ctrl   ctrl;
    t_status status;

    // Control state
    logic [CNW-1:0] r_cols;
    logic [RNW-1:0] r_rows;
    logic [RW-1:0]  r_row;
    logic [CW-1:0]  r_col;
    logic           r_flash;
    logic [RW-1:0]  r_top;
    logic [AW-1:0]  r_cnt;
    logic           r_out_valid;

    // Payload registers
    logic [FUNC_W-1:0] r_func;
    logic [CHAR_W-1:0] r_char;
    logic [RROW_W-1:0] r_rrow;
    logic [RCOL_W-1:0] r_rcol;
    logic [CHAR_W-1:0] r_cell;
    logic              r_scr;
    logic [RW-1:0]     r_frow;
    logic [CHAR_W-1:0] r_rd;
    t_result           r_res;
    logic [CHAR_W-1:0] r_mem [DEPTH];

    logic [CNW-1:0]    n_cols;
    logic [RNW-1:0]    n_rows;
    logic [CCFG-1:0]   cfg_cols;
    logic [RCFG-1:0]   cfg_rows;
    logic [CNW-1:0]    cols_m1;
    logic [RNW-1:0]    rows_m1;
    logic [RW-1:0]     map_src;
    logic [RW:0]       map_sum;
    logic [RW-1:0]     map_row;
    logic [RW-1:0]     top_inc;
    logic              accept;
    logic              out_free;
    logic              rd_in_range;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;

    tccs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    // Clamp written sizes to the supported range
    always_comb begin
        cfg_cols = CCFG'(i_cfg_wdata);
        cfg_rows = RCFG'(i_cfg_wdata[CFG_ROWS_W-1:0]);
        if (cfg_cols == '0) begin
            n_cols = CNW'(1);
        end else if (cfg_cols > CCFG'(MAX_COLUMNS)) begin
            n_cols = CNW'(MAX_COLUMNS);
        end else begin
            n_cols = CNW'(cfg_cols);
        end
        if (cfg_rows == '0) begin
            n_rows = RNW'(1);
        end else if (cfg_rows > RCFG'(MAX_ROWS)) begin
            n_rows = RNW'(MAX_ROWS);
        end else begin
            n_rows = RNW'(cfg_rows);
        end
    end

    assign cols_m1 = r_cols - CNW'(1);
    assign rows_m1 = r_rows - RNW'(1);

    // Map a screen row to a store row: one compare and subtract
    assign map_src = (ctrl.op == OP_READ) ? RW'(r_rrow) : r_row;
    assign map_sum = {1'b0, r_top} + {1'b0, map_src};
    assign map_row = (map_sum >= (RW + 1)'(r_rows)) ? RW'(map_sum - (RW + 1)'(r_rows))
                                                    : RW'(map_sum);
    assign top_inc = ((RNW'(r_top) + RNW'(1)) == r_rows) ? '0 : r_top + RW'(1);

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign rd_in_range = (RCMP'(r_rrow) < RCMP'(r_rows)) && (CCMP'(r_rcol) < CCMP'(r_cols));

    // Status to the sequencer
    always_comb begin
        status.accept       = accept;
        status.top_ok       = RNW'(r_top) < r_rows;
        status.no_wrap      = (CNW'(r_col) + CNW'(1)) < r_cols;
        status.no_scroll    = (RNW'(r_row) + RNW'(1)) < r_rows;
        status.fill_done    = CNW'(r_cnt[CW-1:0]) == cols_m1;
        status.clear_done   = r_cnt == AW'(DEPTH - 1);
        status.out_free     = out_free;
        status.func         = r_func;
        status.is_newline   = r_char == CH_NEWLINE;
        status.is_backspace = r_char == CH_BACKSPACE;
    end

    // Store write port: clear sweep, put, scroll fill
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = '0;
        case (ctrl.op)
            OP_CLEAR: begin
                mem_we = 1'b1;
            end
            OP_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = {map_row, r_col};
                mem_wdata = r_char;
            end
            OP_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = {r_frow, r_cnt[CW-1:0]};
                mem_wdata = CH_SPACE;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_raddr = {map_row, CW'(r_rcol)};

    // Character store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    // Cursor, flag, offset, sizes and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= CNW'(COLS_RST);
            r_rows  <= RNW'(ROWS_RST);
            r_row   <= '0;
            r_col   <= '0;
            r_flash <= 1'b0;
            r_top   <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_COLUMNS: r_cols <= n_cols;
                    CFG_ROWS:    r_rows <= n_rows;
                    default:     r_cols <= r_cols;
                endcase
            end
            case (ctrl.op)
                OP_CLEAR: begin
                    r_cnt <= r_cnt + AW'(1);
                end
                OP_NORM: begin
                    if (RNW'(r_top) >= r_rows) begin
                        r_top <= RW'(RNW'(r_top) - r_rows);
                    end
                    if (RNW'(r_row) >= r_rows) begin
                        r_row <= RW'(rows_m1);
                    end
                    if (CNW'(r_col) >= r_cols) begin
                        r_col <= CW'(cols_m1);
                    end
                end
                OP_TOGGLE: begin
                    r_flash <= !r_flash;
                end
                OP_HOME: begin
                    r_row <= '0;
                    r_col <= '0;
                end
                OP_BACK: begin
                    if (r_col != '0) begin
                        r_col <= r_col - CW'(1);
                    end else if (r_row != '0) begin
                        r_col <= CW'(cols_m1);
                        r_row <= r_row - RW'(1);
                    end
                end
                OP_PUT: begin
                    r_col <= r_col + CW'(1);
                end
                OP_NEWLINE: begin
                    r_col <= '0;
                    r_cnt <= '0;
                    if (status.no_scroll) begin
                        r_row <= r_row + RW'(1);
                    end else begin
                        r_top <= top_inc;
                    end
                end
                OP_FILL: begin
                    r_cnt <= r_cnt + AW'(1);
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    // Command word, read data and scroll marker
    always_ff @(posedge i_clk) begin
        case (ctrl.op)
            OP_IDLE: begin
                if (accept) begin
                    r_func <= i_cmd.func;
                    r_char <= i_cmd.char_code;
                    r_rrow <= i_cmd.read_row;
                    r_rcol <= i_cmd.read_col;
                    r_cell <= '0;
                    r_scr  <= 1'b0;
                end
            end
            OP_RDDATA: begin
                if (rd_in_range) begin
                    r_cell <= r_rd;
                end
            end
            OP_NEWLINE: begin
                if (!status.no_scroll) begin
                    r_frow <= r_top;
                    r_scr  <= 1'b1;
                end
            end
            default: begin
                r_cell <= r_cell;
            end
        endcase
    end

    // Result register: load in the final step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.op == OP_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.op == OP_EMIT && out_free) begin
            r_res.cursor_row      <= CUR_ROW_W'(r_row);
            r_res.cursor_col      <= CUR_COL_W'(r_col);
            r_res.cursor_inverted <= r_flash;
            r_res.cell_char       <= r_cell;
            r_res.scrolled        <= r_scr;
        end
    end

    assign i_cmd.ready           = ctrl.op == OP_IDLE;
    assign o_res.valid           = r_out_valid;
    assign o_res.cursor_row      = r_res.cursor_row;
    assign o_res.cursor_col      = r_res.cursor_col;
    assign o_res.cursor_inverted = r_res.cursor_inverted;
    assign o_res.cell_char       = r_res.cell_char;
    assign o_res.scrolled        = r_res.scrolled;

endmodule

// ===== hw/rtl/tccs_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_seq: microcode sequencer of the text console
// Step counter, control store and next-address logic with a dispatch map.
// ----------------------------------------------------------------------------
module tccs_seq import tccs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_step r_pc;
    t_step n_pc;
    t_step map_target;
    t_ctrl ctrl;
    logic  cond_true;

    // Control store
    always_comb begin
        case (r_pc)
            S_CLEAR:    ctrl = '{OP_CLEAR,   COND_CLEAR_DONE, 1'b1, S_IDLE};
            S_IDLE:     ctrl = '{OP_IDLE,    COND_ACCEPT,     1'b1, S_NORM};
            S_NORM:     ctrl = '{OP_NORM,    COND_TOP_OK,     1'b1, S_DISPATCH};
            S_DISPATCH: ctrl = '{OP_NOP,     COND_DISPATCH,   1'b0, S_IDLE};
            S_TOGGLE:   ctrl = '{OP_TOGGLE,  COND_ALWAYS,     1'b0, S_EMIT};
            S_HOME:     ctrl = '{OP_HOME,    COND_ALWAYS,     1'b0, S_EMIT};
            S_BACK:     ctrl = '{OP_BACK,    COND_ALWAYS,     1'b0, S_EMIT};
            S_READ:     ctrl = '{OP_READ,    COND_NEVER,      1'b0, S_IDLE};
            S_RDDATA:   ctrl = '{OP_RDDATA,  COND_ALWAYS,     1'b0, S_EMIT};
            S_PUT:      ctrl = '{OP_PUT,     COND_NO_WRAP,    1'b0, S_EMIT};
            S_NEWLINE:  ctrl = '{OP_NEWLINE, COND_NO_SCROLL,  1'b0, S_EMIT};
            S_FILL:     ctrl = '{OP_FILL,    COND_FILL_DONE,  1'b1, S_EMIT};
            S_EMIT:     ctrl = '{OP_EMIT,    COND_OUT_FREE,   1'b1, S_IDLE};
            default:    ctrl = '{OP_NOP,     COND_ALWAYS,     1'b0, S_IDLE};
        endcase
    end

    // Dispatch map: entry step of each command
    always_comb begin
        case (i_status.func)
            FUNC_TOGGLE: map_target = S_TOGGLE;
            FUNC_HOME:   map_target = S_HOME;
            FUNC_READ:   map_target = S_READ;
            FUNC_PUT: begin
                if (i_status.is_newline) begin
                    map_target = S_NEWLINE;
                end else if (i_status.is_backspace) begin
                    map_target = S_BACK;
                end else begin
                    map_target = S_PUT;
                end
            end
            default:     map_target = S_PUT;
        endcase
    end

    // Evaluate the jump condition
    always_comb begin
        case (ctrl.cond)
            COND_NEVER:      cond_true = 1'b0;
            COND_ALWAYS:     cond_true = 1'b1;
            COND_ACCEPT:     cond_true = i_status.accept;
            COND_TOP_OK:     cond_true = i_status.top_ok;
            COND_DISPATCH:   cond_true = 1'b1;
            COND_NO_WRAP:    cond_true = i_status.no_wrap;
            COND_NO_SCROLL:  cond_true = i_status.no_scroll;
            COND_FILL_DONE:  cond_true = i_status.fill_done;
            COND_CLEAR_DONE: cond_true = i_status.clear_done;
            COND_OUT_FREE:   cond_true = i_status.out_free;
            default:         cond_true = 1'b0;
        endcase
    end

    // Next address: dispatch, jump, hold or step on
    always_comb begin
        if (ctrl.cond == COND_DISPATCH) begin
            n_pc = map_target;
        end else if (cond_true) begin
            n_pc = ctrl.target;
        end else if (ctrl.hold) begin
            n_pc = r_pc;
        end else begin
            n_pc = r_pc + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_CLEAR;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = ctrl;

endmodule

// ===== hw/rtl/tccs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_checker: port-level checks of the text console
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module tccs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    tccs_in_if.sink    i_cmd,
    tccs_out_if.source i_res
);

    // Hold off commands and results while the store sweep starts
    a_sweep_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_cmd.ready && !i_res.valid)
        else $error("command taken or result shown right after reset");

    // One command at a time: ready drops after a word is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> !i_cmd.ready)
        else $error("second command taken while one is in flight");

    // A scroll always leaves the cursor at column zero
    a_scroll_home_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.valid && i_res.scrolled |-> i_res.cursor_col == '0)
        else $error("scrolled word with cursor off column zero");

    // Only reads return a cell, and a read never scrolls
    a_scroll_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.valid && i_res.scrolled |-> i_res.cell_char == '0)
        else $error("scrolled word carries a cell character");

    // Stalled result word holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.valid && !i_res.ready |=>
            i_res.valid && $stable(i_res.cursor_row) && $stable(i_res.cell_char))
        else $error("result word changed while stalled");

endmodule

bind text_console_cursor_scroll tccs_checker u_tccs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_cmd   (i_cmd),
    .i_res   (o_res)
);
